// ===== hdl/lazy_delete_ordered_table_assert.svh =====
// ----------------------------------------------------------------------------
// lazy delete ordered table assertion macros
// shared property forms for the checker, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef LAZY_DELETE_ORDERED_TABLE_ASSERT_SVH
`define LAZY_DELETE_ORDERED_TABLE_ASSERT_SVH

// same-cycle implication
`define LDOT_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define LDOT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hdl/ldot_pkg.sv =====
// ----------------------------------------------------------------------------
// ldot_pkg
// types, codes and sizes shared by the lazy delete ordered table
// ----------------------------------------------------------------------------
package ldot_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 5;
    localparam int STAT_W       = 3;
    localparam int CNT_OUT_W    = 6;

    // opcode field codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic {
        K_INSERT,
        K_REMOVE
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [DATA_W-1:0]  value;
        logic [IDX_W-1:0]          index;
    } t_cmd;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  removed_value;
        logic                      compacted;
        logic [CNT_OUT_W-1:0]      stored_count;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_COMP,
        S_RESP
    } t_state;

endpackage

// ===== hdl/lazy_delete_ordered_table.sv =====
// ----------------------------------------------------------------------------
// lazy_delete_ordered_table
// ordered table of signed words, newest first, with lazy removal and compaction
// ----------------------------------------------------------------------------
// Each input transfer carries one command and yields exactly one result
// transfer. Insert puts a word in front of the table, remove marks the
// index-th live word (counted from the newest) as deleted and returns it;
// once deleted words outnumber half the stored ones the table is compacted
// in place. Commands are worked one at a time. An insert or a failed remove
// goes from the queue straight to the result stage; a successful remove
// first scans the table ram from the newest word down, one word per cycle
// through its single read port, and a remove that compacts then makes a
// copy pass over the table from the oldest word up. Commands queued ahead
// and a stalled result hold a result back further. A two-deep command
// queue keeps the input side open while the back end is busy, and the
// result register lets the next command start while a finished result
// still waits for the far side to take it.
module lazy_delete_ordered_table
    import ldot_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_index,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic                     o_compacted,
    output logic [CNT_OUT_W-1:0]     o_stored_count
);

    // front to back command hand-over
    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_pop;
    t_result w_res;

    // front: accepts transfers, classifies the opcode, queues commands
    ldot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_pop       (w_pop)
    );

    // back: owns the table, its counts and the result register
    ldot_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (w_res)
    );

    // unpack the result register onto the ports
    assign o_status        = w_res.status;
    assign o_removed_value = w_res.removed_value;
    assign o_compacted     = w_res.compacted;
    assign o_stored_count  = w_res.stored_count;

endmodule

// ===== hdl/ldot_ram.sv =====
// ----------------------------------------------------------------------------
// ldot_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ldot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ldot_front.sv =====
// ----------------------------------------------------------------------------
// ldot_front
// input side: takes transfers, classifies the opcode, holds a two-deep queue
// ----------------------------------------------------------------------------
module ldot_front
    import ldot_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_index,
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd,
    input  logic                     i_pop
);

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic       w_push;
    t_cmd       w_cmd;

    // opcode decode
    always_comb begin
        w_cmd.value = i_value;
        w_cmd.index = i_index;
        unique case (i_opcode)
            OP_INSERT: w_cmd.kind = K_INSERT;
            OP_REMOVE: w_cmd.kind = K_REMOVE;
            default:   w_cmd.kind = K_INSERT;
        endcase
    end

    assign o_stall     = r_fill[1];
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rptr];
    assign n_fill      = r_fill + {1'b0, w_push} - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_fill <= n_fill;
        end
    end

endmodule

// ===== hdl/ldot_back.sv =====
// ----------------------------------------------------------------------------
// ldot_back
// execution side: table store, live-entry scan, compaction and result register
// ----------------------------------------------------------------------------
module ldot_back
    import ldot_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_del, n_del;
    logic [IDX_W-1:0]         r_target, n_target;
    logic [IDX_W-1:0]         r_hits, n_hits;
    logic [AW-1:0]            r_addr, n_addr;
    logic [AW-1:0]            r_daddr, n_daddr;
    logic                     r_pend, n_pend;
    logic [CW-1:0]            r_src, n_src;
    logic [CW-1:0]            r_dst, n_dst;
    logic [AW-1:0]            r_faddr, n_faddr;
    logic signed [DATA_W-1:0] r_fval, n_fval;
    t_result                  r_res, n_res;
    logic                     r_o_valid, n_o_valid;
    t_result                  r_o, n_o;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [DATA_W:0]          w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [DATA_W:0]          w_rdata;
    logic [CW-1:0]            w_live;
    logic                     w_out_free;
    logic                     w_rd_live;

    // word layout: deleted mark on top, value below
    ldot_ram #(
        .WIDTH (DATA_W + 1),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_live     = r_count - r_del;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_rd_live  = r_pend && !w_rdata[DATA_W];
    assign o_valid    = r_o_valid;
    assign o_res      = r_o;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_del     = r_del;
        n_target  = r_target;
        n_hits    = r_hits;
        n_addr    = r_addr;
        n_daddr   = r_daddr;
        n_pend    = 1'b0;
        n_src     = r_src;
        n_dst     = r_dst;
        n_faddr   = r_faddr;
        n_fval    = r_fval;
        n_res     = r_res;
        n_o_valid = r_o_valid;
        n_o       = r_o;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_raddr   = '0;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop                = 1'b1;
                    n_res.removed_value = '0;
                    n_res.compacted      = 1'b0;
                    n_res.stored_count   = CNT_OUT_W'(r_count);
                    n_state              = S_RESP;
                    if (i_cmd.kind == K_INSERT) begin
                        if (r_count == CAP_C) begin
                            n_res.status = ST_FULL;
                        end else begin
                            // new entry at the top address, mark cleared
                            w_we               = 1'b1;
                            w_waddr            = r_count[AW-1:0];
                            w_wdata            = {1'b0, i_cmd.value};
                            n_count            = r_count + ONE_C;
                            n_res.status       = ST_INSERTED;
                            n_res.stored_count = CNT_OUT_W'(r_count + ONE_C);
                        end
                    end else if (w_live == '0) begin
                        n_res.status = ST_EMPTY;
                    end else if (CMPW'(i_cmd.index) >= CMPW'(w_live)) begin
                        n_res.status = ST_RANGE;
                    end else begin
                        n_target = i_cmd.index;
                        n_hits   = '0;
                        n_addr   = AW'(r_count - ONE_C);
                        n_state  = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // newest entry sits at the highest address
                w_raddr = r_addr;
                n_addr  = r_addr - AW'(1);
                n_daddr = r_addr;
                n_pend  = 1'b1;
                if (w_rd_live) begin
                    if (r_hits == r_target) begin
                        n_faddr = r_daddr;
                        n_fval  = w_rdata[DATA_W-1:0];
                        n_pend  = 1'b0;
                        n_state = S_MARK;
                    end else begin
                        n_hits = r_hits + IDX_W'(1);
                    end
                end
            end

            S_MARK: begin
                w_we    = 1'b1;
                w_waddr = r_faddr;
                w_wdata = {1'b1, r_fval};
                n_del   = r_del + ONE_C;
                if ((r_del + ONE_C) > (r_count >> 1)) begin
                    n_src   = '0;
                    n_dst   = '0;
                    n_state = S_COMP;
                end else begin
                    n_res.status        = ST_REMOVED;
                    n_res.removed_value = r_fval;
                    n_res.compacted     = 1'b0;
                    n_res.stored_count  = CNT_OUT_W'(r_count);
                    n_state             = S_RESP;
                end
            end

            S_COMP: begin
                // read from the oldest up, write live words down to r_dst
                if (r_src != r_count) begin
                    w_raddr = r_src[AW-1:0];
                    n_src   = r_src + ONE_C;
                    n_pend  = 1'b1;
                end
                if (w_rd_live) begin
                    w_we    = 1'b1;
                    w_waddr = r_dst[AW-1:0];
                    w_wdata = w_rdata;
                    n_dst   = r_dst + ONE_C;
                end
                if ((r_src == r_count) && !r_pend) begin
                    n_count             = r_dst;
                    n_del               = '0;
                    n_res.status        = ST_REMOVED;
                    n_res.removed_value = r_fval;
                    n_res.compacted     = 1'b1;
                    n_res.stored_count  = CNT_OUT_W'(r_dst);
                    n_state             = S_RESP;
                end
            end

            S_RESP: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o       = r_res;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_del     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_del     <= n_del;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_hits   <= n_hits;
        r_addr   <= n_addr;
        r_daddr  <= n_daddr;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_faddr  <= n_faddr;
        r_fval   <= n_fval;
        r_res    <= n_res;
        r_o      <= n_o;
    end

endmodule

// ===== hdl/ldot_checker.sv =====
// ----------------------------------------------------------------------------
// ldot_checker
// port-level checks on the result channel of the ordered table
// ----------------------------------------------------------------------------
`include "lazy_delete_ordered_table_assert.svh"

module ldot_checker
    import ldot_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic [STAT_W-1:0]        o_status,
    input logic signed [DATA_W-1:0] o_removed_value,
    input logic                     o_compacted,
    input logic [CNT_OUT_W-1:0]     o_stored_count
);

    // a value comes back only with a successful remove
    `LDOT_ASSERT_IMPLY(a_value_zero, o_valid && (o_status != ST_REMOVED),
                       o_removed_value == '0)

    // compaction only follows a successful remove
    `LDOT_ASSERT_IMPLY(a_compact_removed, o_valid && o_compacted, o_status == ST_REMOVED)

    // full is reported only with the table at capacity
    `LDOT_ASSERT_IMPLY(a_full_count, o_valid && (o_status == ST_FULL),
                       o_stored_count == CNT_OUT_W'(CAPACITY))

    // a stalled result holds
    `LDOT_ASSERT_NEXT(a_result_hold, o_valid && i_stall,
                      o_valid && $stable(o_status) && $stable(o_removed_value)
                      && $stable(o_compacted) && $stable(o_stored_count))

endmodule

bind lazy_delete_ordered_table ldot_checker #(.CAPACITY(CAPACITY)) u_ldot_checker (.*);
